// File: rtl/core/layer_norm_row_unit_macros.svh
// ----------------------------------------------------------------------------
// Layer norm row unit assertion macros
// Shared property templates for the concurrent checks in the RTL.
// ----------------------------------------------------------------------------
`ifndef LAYER_NORM_ROW_UNIT_MACROS_SVH
`define LAYER_NORM_ROW_UNIT_MACROS_SVH

// same-cycle implication
`define LNR_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("layer norm row unit: check failed");

// next-cycle implication
`define LNR_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("layer norm row unit: check failed");

`endif

// File: rtl/core/lnr_pkg.sv
// ----------------------------------------------------------------------------
// Layer norm row package
// Shared widths, payload structs, register indexes and back-end states.
// ----------------------------------------------------------------------------
package lnr_pkg;

   localparam int MAX_ROW_DEF = 64;
   localparam int DATA_W      = 16;
   localparam int CNT_W       = 7;
   localparam int SUM_W       = 23;
   localparam int EPS_W       = 16;
   localparam int CSR_IDX_W   = 2;
   localparam int DIVN_W      = 49;
   localparam int DIVD_W      = 34;
   localparam int RSTD_W      = 24;
   localparam int SQ_W        = 55;
   localparam int D_W         = 26;
   localparam int P1_W        = 51;
   localparam int NORM_W      = 35;
   localparam int ACC_W       = 52;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_LENGTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_EPSILON     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BIAS_ENABLE = 2'd2;

   typedef struct packed {
      logic signed [DATA_W-1:0] x_value;
      logic signed [DATA_W-1:0] weight_value;
      logic signed [DATA_W-1:0] bias_value;
   } req_payload_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] y_value;
      logic                     last_of_row;
   } rsp_payload_type;

   // one completed row waiting for the back end
   typedef struct packed {
      logic [CNT_W-1:0]        n;
      logic signed [SUM_W-1:0] sum;
      logic [EPS_W-1:0]        epsilon;
      logic                    bias_enable;
      logic                    bank;
   } job_type;

   // element store write port
   typedef struct packed {
      logic            en;
      logic            bank;
      logic [CNT_W-1:0] idx;
      req_payload_type data;
   } buf_write_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MEAN,
      ST_MEAN_WAIT,
      ST_VAR_RD,
      ST_VAR_ACC,
      ST_VAR_DIV,
      ST_VAR_WAIT,
      ST_LIM,
      ST_LIM_WAIT,
      ST_RSQ,
      ST_OUT_RD,
      ST_OUT_MUL1,
      ST_OUT_NORM,
      ST_OUT_MUL2,
      ST_OUT_EMIT
   } back_state_type;

endpackage

// File: rtl/core/layer_norm_row_unit.sv
// ----------------------------------------------------------------------------
// Layer norm row unit
// Fixed-point layer normalisation of one row with per-column weight and bias.
// ----------------------------------------------------------------------------
// channel   direction  handshake            payload
// req_      in         req_valid/req_stall  x_value, weight_value, bias_value
// rsp_      out        rsp_valid/rsp_stall  y_value, last_of_row
// csr_      in         csr_valid/csr_ready  csr_index, csr_data
//
// Elements load at one per cycle, while req_stall is low, into a two-bank row
// buffer. The back end runs a 49-step divider three times (mean, variance,
// 2^48 / V) and a 24-step rstd search; the variance pass reads and adds up
// each element, the output pass reads each one, multiplies it by rstd, rounds,
// applies weight and bias and emits it. A zero V skips the third division.
// The next row loads while the back end works; req_stall rises only when
// both banks hold rows. rsp_stall holds the output register and the back end.
// Reset is synchronous; the buffer needs no clearing.
// ----------------------------------------------------------------------------
module layer_norm_row_unit import lnr_pkg::*; #(
   parameter int MaxRow = MAX_ROW_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_payload_type      req_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_payload_type      rsp_payload,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [EPS_W-1:0]     csr_data
);

   buf_write_type wr;
   logic          push, pop, q_full, head_valid;
   job_type       push_job, head_job;

   lnr_front #(.MaxRow(MaxRow)) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .wr          (wr),
      .push        (push),
      .push_job    (push_job),
      .q_full      (q_full)
   );

   lnr_job_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .pop        (pop),
      .full       (q_full),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   lnr_back #(.MaxRow(MaxRow)) u_back (
      .clock       (clock),
      .reset       (reset),
      .wr          (wr),
      .job_valid   (head_valid),
      .job         (head_job),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

// File: rtl/core/lnr_front.sv
// ----------------------------------------------------------------------------
// Layer norm row front end
// Takes elements, writes them to the row buffer, sums them and queues rows.
// ----------------------------------------------------------------------------
module lnr_front import lnr_pkg::*; #(
   parameter int MaxRow = MAX_ROW_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_payload_type      req_payload,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [EPS_W-1:0]     csr_data,
   output buf_write_type        wr,
   output logic                 push,
   output job_type              push_job,
   input  logic                 q_full
);

   logic [CNT_W-1:0]        row_length_ff;
   logic [EPS_W-1:0]        epsilon_ff;
   logic                    bias_enable_ff;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic                    bank_ff, bank_in;

   logic                    accept;
   logic [CNT_W-1:0]        len;
   logic [CNT_W-1:0]        cnt_next;
   logic signed [SUM_W-1:0] sum_next;
   logic                    row_end;

   // both banks busy: hold the input
   assign req_stall = q_full;
   assign accept    = req_valid & ~q_full;
   assign csr_ready = 1'b1;

   // effective row length
   always_comb begin
      if (row_length_ff == '0) begin
         len = CNT_W'(1);
      end else if (row_length_ff > CNT_W'(MaxRow)) begin
         len = CNT_W'(MaxRow);
      end else begin
         len = row_length_ff;
      end
   end

   assign cnt_next = count_ff + CNT_W'(1);
   assign sum_next = sum_ff +
                     {{(SUM_W-DATA_W){req_payload.x_value[DATA_W-1]}}, req_payload.x_value};
   assign row_end  = accept && (cnt_next >= len);

   // buffer write and row hand-off
   always_comb begin
      wr.en                = accept;
      wr.bank              = bank_ff;
      wr.idx               = count_ff;
      wr.data              = req_payload;
      push                 = row_end;
      push_job.n           = cnt_next;
      push_job.sum         = sum_next;
      push_job.epsilon     = epsilon_ff;
      push_job.bias_enable = bias_enable_ff;
      push_job.bank        = bank_ff;
   end

   always_comb begin
      count_in = count_ff;
      sum_in   = sum_ff;
      bank_in  = bank_ff;
      if (row_end) begin
         count_in = '0;
         sum_in   = '0;
         bank_in  = ~bank_ff;
      end else if (accept) begin
         count_in = cnt_next;
         sum_in   = sum_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         sum_ff   <= '0;
         bank_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         sum_ff   <= sum_in;
         bank_ff  <= bank_in;
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         row_length_ff  <= CNT_W'(64);
         epsilon_ff     <= EPS_W'(1);
         bias_enable_ff <= 1'b1;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_ROW_LENGTH:  row_length_ff  <= csr_data[CNT_W-1:0];
            CSR_EPSILON:     epsilon_ff     <= csr_data;
            CSR_BIAS_ENABLE: bias_enable_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

endmodule

// File: rtl/core/lnr_job_queue.sv
// ----------------------------------------------------------------------------
// Layer norm row job queue
// Two-entry queue of completed rows, one per buffer bank.
// ----------------------------------------------------------------------------
module lnr_job_queue import lnr_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   input  logic    pop,
   output logic    full,
   output logic    head_valid,
   output job_type head_job
);

   job_type    entry_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff, count_in;

   assign full       = (count_ff == 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head_job   = entry_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
      end
   end

   // payload storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// File: rtl/core/lnr_divider.sv
// ----------------------------------------------------------------------------
// Layer norm row divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lnr_divider import lnr_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DIVN_W-1:0] dividend,
   input  logic [DIVD_W-1:0] divisor,
   output logic              done,
   output logic [DIVN_W-1:0] quotient
);

   localparam int STEP_W = $clog2(DIVN_W + 1);

   logic [STEP_W-1:0] step_ff;
   logic              busy_ff;
   logic              done_ff;
   logic [DIVD_W:0]   rem_ff;
   logic [DIVN_W-1:0] quo_ff;
   logic [DIVD_W-1:0] dvs_ff;

   logic [DIVD_W:0]   trial;
   logic              fits;

   assign trial    = {rem_ff[DIVD_W-1:0], quo_ff[DIVN_W-1]};
   assign fits     = (trial >= {1'b0, dvs_ff});
   assign done     = done_ff;
   assign quotient = quo_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= STEP_W'(DIVN_W);
         end else if (busy_ff) begin
            step_ff <= step_ff - STEP_W'(1);
            if (step_ff == STEP_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // shift-subtract datapath
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= dividend;
         dvs_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= fits ? (trial - {1'b0, dvs_ff}) : trial;
         quo_ff <= {quo_ff[DIVN_W-2:0], fits};
      end
   end

endmodule

// File: rtl/core/lnr_back.sv
// ----------------------------------------------------------------------------
// Layer norm row back end
// Holds the row buffer; mean, variance, rstd and the output pass per row.
// ----------------------------------------------------------------------------
`include "layer_norm_row_unit_macros.svh"

module lnr_back import lnr_pkg::*; #(
   parameter int MaxRow = MAX_ROW_DEF
) (
   input  logic            clock,
   input  logic            reset,
   input  buf_write_type   wr,
   input  logic            job_valid,
   input  job_type         job,
   output logic            pop,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload
);

   localparam int AW    = (MaxRow > 1) ? $clog2(MaxRow) : 1;
   localparam int DEPTH = 2 ** (AW + 1);

   // row buffer, two banks
   req_payload_type mem [DEPTH];
   req_payload_type rd_data_ff;
   logic            rd_en;

   back_state_type          state_ff, state_in;
   logic [CNT_W-1:0]        idx_ff;
   logic signed [D_W-1:0]   mean_ff;
   logic [SQ_W-1:0]         sumsq_ff;
   logic [DIVD_W-1:0]       vsum_ff;
   logic [DIVN_W-1:0]       limit_ff;
   logic [RSTD_W-1:0]       rstd_ff;
   logic [4:0]              bit_ff;
   logic signed [P1_W-1:0]  prod1_ff;
   logic signed [NORM_W-1:0] norm_ff;
   logic signed [ACC_W-1:0] acc_ff;
   logic                    rsp_valid_ff;
   rsp_payload_type         rsp_payload_ff;

   logic                    div_start;
   logic [DIVN_W-1:0]       div_dividend;
   logic [DIVD_W-1:0]       div_divisor;
   logic                    div_done;
   logic [DIVN_W-1:0]       div_quo;

   logic                    rsp_load;
   logic                    idx_last;

   logic                    sum_neg;
   logic [SUM_W-1:0]        sum_mag;
   logic [30:0]             mean_num;
   logic [55:0]             var_num;
   logic signed [D_W-1:0]   d_val;
   logic signed [2*D_W-1:0] d_sq;
   logic [RSTD_W-1:0]       cand;
   logic [2*RSTD_W-1:0]     cand_sq;
   logic [P1_W-1:0]         p1_mag;
   logic [P1_W-17:0]        n_mag;
   logic [ACC_W-1:0]        acc_mag;
   logic [ACC_W-17:0]       y_mag;
   logic signed [DATA_W-1:0] y_sat;

   lnr_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quo)
   );

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[{wr.bank, wr.idx[AW-1:0]}] <= wr.data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[{job.bank, idx_ff[AW-1:0]}];
      end
   end

   assign idx_last = (idx_ff + CNT_W'(1) == job.n);

   // mean numerator: |sum| * 256 + n / 2
   assign sum_neg  = job.sum[SUM_W-1];
   assign sum_mag  = sum_neg ? SUM_W'(-job.sum) : SUM_W'(job.sum);
   assign mean_num = {sum_mag, 8'b0} + 31'(job.n >> 1);

   // variance numerator: sumsq + n * 2^15
   assign var_num  = {1'b0, sumsq_ff} + (56'(job.n) << 15);

   // deviation of the buffered element
   assign d_val = $signed({{(D_W-24){rd_data_ff.x_value[DATA_W-1]}},
                           rd_data_ff.x_value, 8'b0}) - mean_ff;
   assign d_sq  = d_val * d_val;

   // one bit of the square-root search
   assign cand    = rstd_ff | (RSTD_W'(1) << bit_ff);
   assign cand_sq = cand * cand;

   // rounding to nearest, ties away from zero
   assign p1_mag  = prod1_ff[P1_W-1] ? P1_W'(-prod1_ff) : P1_W'(prod1_ff);
   assign n_mag   = (P1_W-16)'((p1_mag + P1_W'(32768)) >> 16);
   assign acc_mag = acc_ff[ACC_W-1] ? ACC_W'(-acc_ff) : ACC_W'(acc_ff);
   assign y_mag   = (ACC_W-16)'((acc_mag + ACC_W'(32768)) >> 16);

   always_comb begin
      if (acc_ff[ACC_W-1]) begin
         y_sat = (y_mag > (ACC_W-16)'(32768)) ? DATA_W'(-32768)
                                             : DATA_W'(-$signed({1'b0, y_mag}));
      end else begin
         y_sat = (y_mag > (ACC_W-16)'(32767)) ? DATA_W'(32767) : DATA_W'(y_mag);
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:      if (job_valid) state_in = ST_MEAN;
         ST_MEAN:      state_in = ST_MEAN_WAIT;
         ST_MEAN_WAIT: if (div_done) state_in = ST_VAR_RD;
         ST_VAR_RD:    state_in = ST_VAR_ACC;
         ST_VAR_ACC:   state_in = idx_last ? ST_VAR_DIV : ST_VAR_RD;
         ST_VAR_DIV:   state_in = ST_VAR_WAIT;
         ST_VAR_WAIT:  if (div_done) state_in = ST_LIM;
         ST_LIM:       state_in = (vsum_ff == '0) ? ST_RSQ : ST_LIM_WAIT;
         ST_LIM_WAIT:  if (div_done) state_in = ST_RSQ;
         ST_RSQ:       if (bit_ff == 5'd0) state_in = ST_OUT_RD;
         ST_OUT_RD:    state_in = ST_OUT_MUL1;
         ST_OUT_MUL1:  state_in = ST_OUT_NORM;
         ST_OUT_NORM:  state_in = ST_OUT_MUL2;
         ST_OUT_MUL2:  state_in = ST_OUT_EMIT;
         ST_OUT_EMIT: begin
            if (rsp_load) begin
               state_in = idx_last ? ST_IDLE : ST_OUT_RD;
            end
         end
         default:      state_in = ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      div_start    = 1'b0;
      div_dividend = DIVN_W'(mean_num);
      div_divisor  = DIVD_W'(job.n);
      rd_en        = 1'b0;
      rsp_load     = 1'b0;
      pop          = 1'b0;
      case (state_ff)
         ST_MEAN: div_start = 1'b1;
         ST_VAR_DIV: begin
            div_start    = 1'b1;
            div_dividend = DIVN_W'(var_num[55:16]);
         end
         ST_LIM: begin
            div_start    = (vsum_ff != '0);
            div_dividend = DIVN_W'(1) << 48;
            div_divisor  = vsum_ff;
         end
         ST_VAR_RD, ST_OUT_RD: rd_en = 1'b1;
         ST_OUT_EMIT: begin
            rsp_load = !rsp_valid_ff || !rsp_stall;
            pop      = rsp_load && idx_last;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_MEAN_WAIT: begin
            if (div_done) begin
               mean_ff  <= sum_neg ? -$signed(D_W'(div_quo[23:0]))
                                   : $signed(D_W'(div_quo[23:0]));
               idx_ff   <= '0;
               sumsq_ff <= '0;
            end
         end
         ST_VAR_ACC: begin
            sumsq_ff <= sumsq_ff + SQ_W'(d_sq[48:0]);
            idx_ff   <= idx_ff + CNT_W'(1);
         end
         ST_VAR_WAIT: begin
            if (div_done) begin
               vsum_ff <= DIVD_W'(div_quo[32:0]) + DIVD_W'(job.epsilon);
            end
         end
         ST_LIM: begin
            limit_ff <= '1;
            rstd_ff  <= '0;
            bit_ff   <= 5'(RSTD_W - 1);
         end
         ST_LIM_WAIT: begin
            if (div_done) begin
               limit_ff <= div_quo;
            end
         end
         ST_RSQ: begin
            if ({1'b0, cand_sq} <= limit_ff) begin
               rstd_ff <= cand;
            end
            bit_ff <= bit_ff - 5'd1;
            idx_ff <= '0;
         end
         ST_OUT_MUL1: prod1_ff <= d_val * $signed({1'b0, rstd_ff});
         ST_OUT_NORM: norm_ff <= prod1_ff[P1_W-1] ? -$signed(NORM_W'(n_mag))
                                                  : $signed(NORM_W'(n_mag));
         ST_OUT_MUL2: begin
            // bias is signed Q8.8, moved up to Q28.24 with its sign kept
            acc_ff <= ACC_W'(norm_ff * rd_data_ff.weight_value) +
                      (job.bias_enable ? ACC_W'($signed({rd_data_ff.bias_value, 16'b0}))
                                       : '0);
         end
         ST_OUT_EMIT: begin
            if (rsp_load) begin
               rsp_payload_ff.y_value     <= y_sat;
               rsp_payload_ff.last_of_row <= idx_last;
               idx_ff                     <= idx_ff + CNT_W'(1);
            end
         end
         default: ;
      endcase
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   `LNR_ASSERT_IMP(a_busy_has_job, clock, reset, state_ff != ST_IDLE, job_valid)
   `LNR_ASSERT_IMP(a_idx_in_row, clock, reset, state_ff == ST_VAR_RD || state_ff == ST_OUT_RD, idx_ff < job.n)
   `LNR_ASSERT_NXT(a_pop_idles, clock, reset, pop, state_ff == ST_IDLE)

endmodule
